@@ hw/rtl/mbm_pkg.sv @@
// shared types, constants and bank mapping functions for the multicart bank mapper
package mbm_pkg;

  localparam int CfgWidth    = 11;
  localparam int CfgIdxWidth = 2;

  localparam logic [CfgIdxWidth-1:0] CFG_PRG_RAM_WE = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_PRG_LIMIT  = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CFG_CHR_LIMIT  = 2'd2;

  localparam logic [15:0] ADDR_SEL_MASK = 16'hE001;
  localparam logic [15:0] ADDR_BANK_SEL = 16'h8000;
  localparam logic [15:0] ADDR_BANK_DAT = 16'h8001;
  localparam logic [15:0] ADDR_OUTER_LO = 16'h6000;
  localparam logic [15:0] ADDR_OUTER_HI = 16'h7FFF;

  localparam logic [7:0] PRG_SECOND_LAST = 8'hFE;
  localparam logic [7:0] PRG_LAST        = 8'hFF;

  localparam logic [7:0] INNER_RESET [8] = '{8'd0, 8'd2, 8'd4, 8'd5, 8'd6, 8'd7, 8'd0, 8'd0};

  typedef enum logic [1:0] {
    OP_NONE,
    OP_OUTER,
    OP_SELECT,
    OP_INNER
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] value;
  } cmd_t;

  typedef struct packed {
    logic        prg_ram_write_enable;
    logic [7:0]  prg_bank_limit;
    logic [10:0] chr_bank_limit;
  } cfg_t;

  function automatic logic [2:0] outer_bits(input logic [7:0] outer);
    outer_bits = {outer[6], outer[4:3]};
  endfunction

  function automatic logic use_128k(input logic [7:0] outer);
    use_128k = !(outer[7] && outer[5]);
  endfunction

  function automatic logic [7:0] prg_map(input logic [7:0] outer, input logic [1:0] slot,
                                         input logic [7:0] inner, input logic [7:0] limit);
    logic [7:0] v;
    logic [5:0] bank;
    logic       half;
    if (outer[5]) begin
      if (use_128k(outer)) v = {1'b0, outer_bits(outer), inner[3:0]};
      else v = {outer_bits(outer), inner[4:0]};
    end else begin
      bank = {outer[6], outer[4:0]};
      half = |outer[1:0];
      bank[0] = slot[1] ? (bank[0] | half) : (bank[0] & ~half);
      v = {1'b0, bank, slot[0]};
    end
    if (v > limit) v = v & limit;
    prg_map = v;
  endfunction

  function automatic logic [10:0] chr_map(input logic [7:0] outer, input logic [7:0] inner,
                                          input logic [10:0] limit);
    logic [10:0] v;
    if (use_128k(outer)) v = {1'b0, outer_bits(outer), inner[6:0]};
    else v = {outer_bits(outer), inner};
    if (v > limit) v = v & limit;
    chr_map = v;
  endfunction

endpackage

@@ hw/rtl/mbm_if.sv @@
// channel interfaces: cpu write in, bank mapping out
interface mbm_wr_if;
  logic        valid;
  logic        ready;
  logic [15:0] address;
  logic [7:0]  data;

  modport source (output valid, address, data, input ready);
  modport sink (input valid, address, data, output ready);
endinterface

interface mbm_map_if;
  logic        valid;
  logic        ready;
  logic [7:0]  prg_bank_0;
  logic [7:0]  prg_bank_1;
  logic [7:0]  prg_bank_2;
  logic [7:0]  prg_bank_3;
  logic [10:0] chr_bank_0;
  logic [10:0] chr_bank_1;
  logic [10:0] chr_bank_2;
  logic [10:0] chr_bank_3;
  logic [10:0] chr_bank_4;
  logic [10:0] chr_bank_5;
  logic [10:0] chr_bank_6;
  logic [10:0] chr_bank_7;

  modport source (output valid, prg_bank_0, prg_bank_1, prg_bank_2, prg_bank_3,
                  chr_bank_0, chr_bank_1, chr_bank_2, chr_bank_3,
                  chr_bank_4, chr_bank_5, chr_bank_6, chr_bank_7, input ready);
  modport sink (input valid, prg_bank_0, prg_bank_1, prg_bank_2, prg_bank_3,
                chr_bank_0, chr_bank_1, chr_bank_2, chr_bank_3,
                chr_bank_4, chr_bank_5, chr_bank_6, chr_bank_7, output ready);
endinterface

@@ hw/rtl/mbm_front.sv @@
// front end: accepts cpu writes and decodes them into register commands
module mbm_front (
  mbm_wr_if.sink      wr,
  input  logic        prg_ram_write_enable,
  input  logic        q_full,
  output logic        push,
  output mbm_pkg::cmd_t cmd
);
  import mbm_pkg::*;

  logic [15:0] sel;

  assign wr.ready = !q_full;
  assign push     = wr.valid && !q_full;
  assign sel      = wr.address & ADDR_SEL_MASK;

  always_comb begin
    cmd.op    = OP_NONE;
    cmd.value = wr.data;
    if (wr.address >= ADDR_OUTER_LO && wr.address <= ADDR_OUTER_HI) begin
      // outer register takes the low address byte
      cmd.value = wr.address[7:0];
      if (prg_ram_write_enable) cmd.op = OP_OUTER;
    end else if (wr.address[15]) begin
      unique case (sel)
        ADDR_BANK_SEL: cmd.op = OP_SELECT;
        ADDR_BANK_DAT: cmd.op = OP_INNER;
        default:       cmd.op = OP_NONE;
      endcase
    end
  end

endmodule

@@ hw/rtl/mbm_queue.sv @@
// two-entry command queue between front and back
module mbm_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mbm_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          pop_valid,
  output mbm_pkg::cmd_t pop_cmd
);
  import mbm_pkg::*;

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = count == 2'd2;
  assign pop_valid = count != 2'd0;
  assign pop_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

@@ hw/rtl/mbm_back.sv @@
// back end: applies register commands and registers the resulting bank map
module mbm_back (
  input  logic          clk,
  input  logic          rst,
  input  mbm_pkg::cfg_t cfg,
  input  logic          q_valid,
  input  mbm_pkg::cmd_t q_cmd,
  output logic          pop,
  mbm_map_if.source     map
);
  import mbm_pkg::*;

  logic [7:0]  outer_reg;
  logic [7:0]  bank_select;
  logic [7:0]  inner_banks [8];
  logic [7:0]  outer_next;
  logic [7:0]  select_next;
  logic [7:0]  inner_next [8];
  logic [7:0]  chr_inner [8];
  logic [7:0]  prg_next [4];
  logic [10:0] chr_next [8];
  logic [7:0]  prg [4];
  logic [10:0] chr [8];
  logic        out_valid;

  assign pop = q_valid && (!out_valid || map.ready);

  always_comb begin
    outer_next  = outer_reg;
    select_next = bank_select;
    inner_next  = inner_banks;
    if (pop) begin
      case (q_cmd.op)
        OP_OUTER:  outer_next = q_cmd.value;
        OP_SELECT: select_next = q_cmd.value;
        OP_INNER:  inner_next[bank_select[2:0]] = q_cmd.value;
        default:   ;
      endcase
    end
  end

  always_comb begin
    // bit 6 of bank select swaps the fixed second-last bank with the switchable one
    if (select_next[6]) begin
      prg_next[0] = prg_map(outer_next, 2'd0, PRG_SECOND_LAST, cfg.prg_bank_limit);
      prg_next[2] = prg_map(outer_next, 2'd2, inner_next[6], cfg.prg_bank_limit);
    end else begin
      prg_next[0] = prg_map(outer_next, 2'd0, inner_next[6], cfg.prg_bank_limit);
      prg_next[2] = prg_map(outer_next, 2'd2, PRG_SECOND_LAST, cfg.prg_bank_limit);
    end
    prg_next[1] = prg_map(outer_next, 2'd1, inner_next[7], cfg.prg_bank_limit);
    prg_next[3] = prg_map(outer_next, 2'd3, PRG_LAST, cfg.prg_bank_limit);

    chr_inner[0] = inner_next[0] & 8'hFE;
    chr_inner[1] = inner_next[0] | 8'h01;
    chr_inner[2] = inner_next[1] & 8'hFE;
    chr_inner[3] = inner_next[1] | 8'h01;
    chr_inner[4] = inner_next[2];
    chr_inner[5] = inner_next[3];
    chr_inner[6] = inner_next[4];
    chr_inner[7] = inner_next[5];
    // bit 7 of bank select swaps the two pattern table halves
    for (int j = 0; j < 8; j++) begin
      chr_next[j] = chr_map(outer_next, chr_inner[3'(j) ^ {select_next[7], 2'b00}],
                            cfg.chr_bank_limit);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      outer_reg   <= '0;
      bank_select <= '0;
      inner_banks <= INNER_RESET;
      out_valid   <= 1'b0;
    end else begin
      if (pop) begin
        outer_reg   <= outer_next;
        bank_select <= select_next;
        inner_banks <= inner_next;
        out_valid   <= 1'b1;
      end else if (map.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      prg <= prg_next;
      chr <= chr_next;
    end
  end

  assign map.valid      = out_valid;
  assign map.prg_bank_0 = prg[0];
  assign map.prg_bank_1 = prg[1];
  assign map.prg_bank_2 = prg[2];
  assign map.prg_bank_3 = prg[3];
  assign map.chr_bank_0 = chr[0];
  assign map.chr_bank_1 = chr[1];
  assign map.chr_bank_2 = chr[2];
  assign map.chr_bank_3 = chr[3];
  assign map.chr_bank_4 = chr[4];
  assign map.chr_bank_5 = chr[5];
  assign map.chr_bank_6 = chr[6];
  assign map.chr_bank_7 = chr[7];

endmodule

@@ hw/rtl/multicart_bank_mapper.sv @@
// Multicart outer/inner bank mapper. Every cpu write transfer on wr yields one transfer on map
// carrying the four 8 KiB program banks and eight 1 KiB pattern banks computed after that write
// has updated the outer, bank-select and inner bank registers. One write is taken per cycle while
// the command queue has room; the result passes through the two-entry command queue and then the
// back end, which updates state and registers the map. wr stays ready while the queue has room, so
// a stalled map consumer holds back writes only after three results pile up.
// Configuration (cfg_index 0: program RAM write enable, 1: program bank limit, 2: pattern bank
// limit) is to be written by the user only while no write is in flight; the block does not enforce this.
module multicart_bank_mapper (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [mbm_pkg::CfgIdxWidth-1:0]    cfg_index,
  input  logic [mbm_pkg::CfgWidth-1:0]       cfg_data,
  mbm_wr_if.sink                             wr,
  mbm_map_if.source                          map
);
  import mbm_pkg::*;

  cfg_t cfg;
  cmd_t front_cmd;
  cmd_t q_cmd;
  logic push;
  logic q_full;
  logic q_valid;
  logic pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prg_ram_write_enable <= 1'b0;
      cfg.prg_bank_limit       <= 8'hFF;
      cfg.chr_bank_limit       <= 11'h7FF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PRG_RAM_WE: cfg.prg_ram_write_enable <= cfg_data[0];
        CFG_PRG_LIMIT:  cfg.prg_bank_limit <= cfg_data[7:0];
        CFG_CHR_LIMIT:  cfg.chr_bank_limit <= cfg_data;
        default:        ;
      endcase
    end
  end

  mbm_front u_front (
    .wr                   (wr),
    .prg_ram_write_enable (cfg.prg_ram_write_enable),
    .q_full               (q_full),
    .push                 (push),
    .cmd                  (front_cmd)
  );

  mbm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (front_cmd),
    .full      (q_full),
    .pop       (pop),
    .pop_valid (q_valid),
    .pop_cmd   (q_cmd)
  );

  mbm_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .pop     (pop),
    .map     (map)
  );

endmodule
